// ===== hdl/scx_pkg.sv =====
// Shared types, constants and the Scale3x rule function for the upscaler.
package scx_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int PALETTE_SIZE = 512;
  localparam int CODE_W       = 9;
  localparam int DIM_W        = 9;
  localparam int POS_W        = 8;
  localparam int COLOR_W      = 32;
  localparam int LINE_AW      = $clog2(MAX_WIDTH);
  localparam int PAL_AW       = $clog2(PALETTE_SIZE);
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

  // input kinds (tuser)
  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_PALETTE = 1'b1;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // window rows and columns
  localparam logic [1:0] ROW_OLDER  = 2'd0;
  localparam logic [1:0] ROW_RECENT = 2'd1;
  localparam logic [1:0] ROW_LIVE   = 2'd2;
  localparam logic [1:0] COL_M2     = 2'd0;
  localparam logic [1:0] COL_M1     = 2'd1;
  localparam logic [1:0] COL_CUR    = 2'd2;

  typedef logic [CODE_W-1:0]  code_t;
  typedef code_t [8:0]        nbr_t;     // A..I, or E0..E8
  typedef code_t [2:0]        row3_t;    // cols c-2, c-1, c
  typedef row3_t [2:0]        grid_t;    // older, recent, live rows

  typedef struct packed {
    logic                 is_pal;
    logic [CODE_W-1:0]    pal_addr;
    logic [COLOR_W-1:0]   pal_word;
    grid_t                grid;
    logic [POS_W-1:0]     col;
    logic [POS_W-1:0]     row;
    logic [3:0]           mask;      // blocks: up-left, up, left, here
    logic                 c_ge1;
    logic                 c_ge2;
    logic                 rclamp;
    logic                 r_is0;
    logic                 r_is1;
  } job_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) res = DIM_W'(1);
    else if (v > maxv) res = maxv;
    else res = v;
    return res;
  endfunction

  function automatic nbr_t scale3x(input nbr_t n);
    nbr_t  x;
    code_t a, b, c, d, e, f, g, h, i;
    a = n[0]; b = n[1]; c = n[2];
    d = n[3]; e = n[4]; f = n[5];
    g = n[6]; h = n[7]; i = n[8];
    if (b != h && d != f) begin
      x[0] = (d == b) ? d : e;
      x[1] = ((d == b && e != c) || (b == f && e != a)) ? b : e;
      x[2] = (b == f) ? f : e;
      x[3] = ((d == b && e != g) || (d == h && e != a)) ? d : e;
      x[4] = e;
      x[5] = ((b == f && e != i) || (h == f && e != c)) ? f : e;
      x[6] = (d == h) ? d : e;
      x[7] = ((d == h && e != i) || (h == f && e != g)) ? h : e;
      x[8] = (h == f) ? f : e;
    end else begin
      x = {9{e}};
    end
    return x;
  endfunction

endpackage

// ===== hdl/scale3x_pixel_upscaler_top.sv =====
// Top level of the Scale3x pixel upscaler: config registers, front, queue, back.
//
// Usage:
//  - in_*: one request per pixel code in raster order (tuser = kind 0), or a
//    palette write (tuser = kind 1, code = palette address). Accepted on
//    in_tvalid && in_tready.
//  - out_*: one request per emitted 3x3 block: source col/row and nine palette
//    colors E0..E8; tlast marks the final block caused by one input request.
//  - cfg_*: frame_width (index 0) and frame_height (index 1), always ready;
//    write only while the block is idle.
//  - Throughput: one input per cycle while each input causes at most one
//    block, the queue has room and out_tready stays high; an input that
//    causes n blocks holds the back end until all n are issued (row-end and
//    last-row flushes, up to 4), and the 4-entry queue absorbs short bursts.
//    Palette writes also pass the back end but emit no block. An accepted input
//    passes the front register, queue write, rule stage and palette read to out_*.
//  - Reset clears position counters, the live-row window and all handshake
//    state; the palette and line store hold garbage until written.
//  - A stalled receiver holds out_* steady; the queue fills, then in_tready
//    drops. Nothing is lost or repeated.
module scale3x_pixel_upscaler_top
  import scx_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  // configuration write channel
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,      // 0 frame_width, 1 frame_height
  input  logic [8:0]    cfg_data,
  // input stream
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [47:0]   in_tdata,       // [8:0] pixel_code, [40:9] palette_word, pad
  input  logic [0:0]    in_tuser,       // [0] kind
  // result stream
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [303:0]  out_tdata,      // [7:0] src_col, [15:8] src_row, then
                                        // E0..E8 colors, 32 bits each from bit 16
  output logic          out_tlast       // last_of_run
);

  logic [DIM_W-1:0]     frame_width_r, frame_height_r;
  logic                 push, pop;
  job_t                 push_job, head;
  q_stat_t              q_stat;
  logic [POS_W-1:0]     blk_col, blk_row;
  logic [9*COLOR_W-1:0] colors;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= MAX_W_DIM;
      frame_height_r <= DIM_W'(240);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH:  frame_width_r  <= cfg_data;
        REG_HEIGHT: frame_height_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  scx_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_kind      (in_tuser[0]),
    .in_code      (in_tdata[8:0]),
    .in_word      (in_tdata[40:9]),
    .push         (push),
    .push_job     (push_job),
    .q_stat       (q_stat)
  );

  scx_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  scx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_col    (blk_col),
    .out_row    (blk_row),
    .out_colors (colors),
    .out_last   (out_tlast)
  );

  assign out_tdata = {colors, blk_row, blk_col};

  // queue occupancy never exceeds its depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

  // no push into a full queue, no pop from an empty one
  a_q_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full) && !(pop && q_stat.empty))
    else $error("queue overflow or underflow");

  // reset leaves the queue empty and no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (q_stat.count == '0) && !out_tvalid)
    else $error("reset did not clear queue/output");

endmodule

// ===== hdl/scx_fifo.sv =====
// Short job queue between the front and back parts.
module scx_fifo
  import scx_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

endmodule

// ===== hdl/scx_front.sv =====
// Front part: takes requests, tracks position, keeps line store and windows.
module scx_front
  import scx_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [DIM_W-1:0]   frame_width,
  input  logic [DIM_W-1:0]   frame_height,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [CODE_W-1:0]  in_code,
  input  logic [COLOR_W-1:0] in_word,
  output logic               push,
  output job_t               push_job,
  input  q_stat_t            q_stat
);

  // line store word: older row code above recent row code
  logic [2*CODE_W-1:0] line_mem [MAX_WIDTH];

  logic [POS_W-1:0]    col_r, col_nxt;
  logic [POS_W-1:0]    row_r, row_nxt;
  logic [DIM_W-1:0]    w_eff, h_eff;
  logic                row_end, last_row, rclamp;
  logic                accept, pix_acc;

  logic                b_v_r;
  logic                b_pal_r;
  logic [CODE_W-1:0]   b_code_r;
  logic [COLOR_W-1:0]  b_word_r;
  logic [POS_W-1:0]    b_col_r, b_row_r;
  logic                b_row_end_r, b_last_row_r, b_rclamp_r;
  logic [2*CODE_W-1:0] rd_r, fwd_word_r, cur_word, wr_word;
  logic                fwd_hit_r;
  code_t               ow0_r, ow1_r, rw0_r, rw1_r, iw0_r, iw1_r;
  logic [3:0]          mask;
  logic                need_push, b_fire, b_pix_fire;

  always_comb begin
    w_eff    = clamp_dim(frame_width, MAX_W_DIM);
    h_eff    = clamp_dim(frame_height, MAX_H_DIM);
    row_end  = ({1'b0, col_r} + DIM_W'(1)) >= w_eff;
    last_row = ({1'b0, row_r} + DIM_W'(1)) >= h_eff;
    rclamp   = {1'b0, col_r} >= w_eff;
    accept   = in_valid && in_ready;
    pix_acc  = accept && (in_kind == KIND_PIXEL);
    col_nxt  = row_end ? '0 : col_r + POS_W'(1);
    row_nxt  = row_end ? (last_row ? '0 : row_r + POS_W'(1)) : row_r;
  end

  always_comb begin
    cur_word   = fwd_hit_r ? fwd_word_r : rd_r;
    wr_word    = {cur_word[CODE_W-1:0], b_code_r};
    mask[0]    = (b_row_r != '0) && (b_col_r != '0);
    mask[1]    = (b_row_r != '0) && b_row_end_r;
    mask[2]    = b_last_row_r && (b_col_r != '0);
    mask[3]    = b_last_row_r && b_row_end_r;
    need_push  = b_pal_r || (mask != '0);
    b_fire     = b_v_r && (!need_push || !q_stat.full);
    b_pix_fire = b_fire && !b_pal_r;
    push       = b_v_r && need_push && !q_stat.full;
    in_ready   = !b_v_r || b_fire;
  end

  always_comb begin
    push_job.is_pal   = b_pal_r;
    push_job.pal_addr = b_code_r;
    push_job.pal_word = b_word_r;
    push_job.grid[ROW_OLDER]  = {cur_word[2*CODE_W-1:CODE_W], ow1_r, ow0_r};
    push_job.grid[ROW_RECENT] = {cur_word[CODE_W-1:0], rw1_r, rw0_r};
    push_job.grid[ROW_LIVE]   = {b_code_r, iw1_r, iw0_r};
    push_job.col    = b_col_r;
    push_job.row    = b_row_r;
    push_job.mask   = mask;
    push_job.c_ge1  = (b_col_r != '0);
    push_job.c_ge2  = (b_col_r >= POS_W'(2));
    push_job.rclamp = b_rclamp_r;
    push_job.r_is0  = (b_row_r == '0);
    push_job.r_is1  = (b_row_r == POS_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      b_v_r <= 1'b0;
      iw0_r <= '0;
      iw1_r <= '0;
    end else begin
      if (pix_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (accept) b_v_r <= 1'b1;
      else if (b_fire) b_v_r <= 1'b0;
      if (b_pix_fire) begin
        iw0_r <= iw1_r;
        iw1_r <= b_code_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_pal_r      <= (in_kind == KIND_PALETTE);
      b_code_r     <= in_code;
      b_word_r     <= in_word;
      b_col_r      <= col_r;
      b_row_r      <= row_r;
      b_row_end_r  <= row_end;
      b_last_row_r <= last_row;
      b_rclamp_r   <= rclamp;
      rd_r         <= line_mem[col_r];
      fwd_hit_r    <= b_pix_fire && (b_col_r == col_r);
      fwd_word_r   <= wr_word;
    end
    if (b_pix_fire) begin
      line_mem[b_col_r] <= wr_word;
      ow0_r <= ow1_r;
      ow1_r <= cur_word[2*CODE_W-1:CODE_W];
      rw0_r <= rw1_r;
      rw1_r <= cur_word[CODE_W-1:0];
    end
  end

endmodule

// ===== hdl/scx_back.sv =====
// Back part: walks the blocks of each job, applies rules, maps through palette.
module scx_back
  import scx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  job_t                 head,
  input  q_stat_t              q_stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [POS_W-1:0]     out_col,
  output logic [POS_W-1:0]     out_row,
  output logic [9*COLOR_W-1:0] out_colors,
  output logic                 out_last
);

  logic [COLOR_W-1:0] pal_mem [9][PALETTE_SIZE];

  logic [3:0]         done_r, done_nxt;
  logic [3:0]         pending, pick;
  logic [1:0]         blk;
  logic               more, lower_blk;
  logic [1:0]         rs_top, rs_mid, rs_bot, cs_l, cs_c, cs_r;
  nbr_t               nbr, codes;
  logic [POS_W-1:0]   blk_col, blk_row;

  logic               s1_v_r, s1_pal_r, s1_last_r;
  nbr_t               s1_codes_r;
  logic [COLOR_W-1:0] s1_word_r;
  logic [POS_W-1:0]   s1_col_r, s1_row_r;
  logic               adv2, s1_free, s1_load;

  logic               out_v_r, out_last_r;
  logic [POS_W-1:0]   out_col_r, out_row_r;
  logic [COLOR_W-1:0] color_r [9];

  always_comb begin
    pending = head.mask & ~done_r;
    pick    = pending & (~pending + 4'd1);
    unique case (pick)
      4'b0001: blk = 2'd0;
      4'b0010: blk = 2'd1;
      4'b0100: blk = 2'd2;
      4'b1000: blk = 2'd3;
      default: blk = 2'd0;
    endcase
    more      = (pending & ~pick) != '0;
    lower_blk = (blk == 2'd0) || (blk == 2'd2);
    // rows: blocks 0,1 sit one row up; 2,3 on the live (last) row
    if (blk[1] == 1'b0) begin
      rs_top = head.r_is1 ? ROW_RECENT : ROW_OLDER;
      rs_mid = ROW_RECENT;
      blk_row = head.row - POS_W'(1);
    end else begin
      rs_top = head.r_is0 ? ROW_LIVE : ROW_RECENT;
      rs_mid = ROW_LIVE;
      blk_row = head.row;
    end
    rs_bot = ROW_LIVE;
    if (lower_blk) begin
      cs_l = head.c_ge2 ? COL_M2 : COL_M1;
      cs_c = COL_M1;
      cs_r = head.rclamp ? COL_M1 : COL_CUR;
      blk_col = head.col - POS_W'(1);
    end else begin
      cs_l = head.c_ge1 ? COL_M1 : COL_CUR;
      cs_c = COL_CUR;
      cs_r = COL_CUR;
      blk_col = head.col;
    end
    nbr[0] = head.grid[rs_top][cs_l];
    nbr[1] = head.grid[rs_top][cs_c];
    nbr[2] = head.grid[rs_top][cs_r];
    nbr[3] = head.grid[rs_mid][cs_l];
    nbr[4] = head.grid[rs_mid][cs_c];
    nbr[5] = head.grid[rs_mid][cs_r];
    nbr[6] = head.grid[rs_bot][cs_l];
    nbr[7] = head.grid[rs_bot][cs_c];
    nbr[8] = head.grid[rs_bot][cs_r];
    codes  = scale3x(nbr);
  end

  always_comb begin
    adv2     = !out_v_r || out_ready;
    s1_free  = !s1_v_r || s1_pal_r || adv2;
    s1_load  = !q_stat.empty && s1_free;
    pop      = s1_load && (head.is_pal || !more);
    if (pop) done_nxt = '0;
    else if (s1_load) done_nxt = done_r | pick;
    else done_nxt = done_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r  <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      if (s1_free) s1_v_r <= s1_load;
      if (adv2) out_v_r <= s1_v_r && !s1_pal_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && s1_load) begin
      s1_pal_r  <= head.is_pal;
      s1_word_r <= head.pal_word;
      s1_col_r  <= blk_col;
      s1_row_r  <= blk_row;
      s1_last_r <= !more;
      if (head.is_pal) s1_codes_r <= {9{head.pal_addr}};
      else s1_codes_r <= codes;
    end
  end

  // palette copies: one per output position, all written alike
  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      if (s1_v_r && s1_pal_r) begin
        pal_mem[k][s1_codes_r[k][PAL_AW-1:0]] <= s1_word_r;
      end
      if (adv2 && s1_v_r && !s1_pal_r) begin
        color_r[k] <= pal_mem[k][s1_codes_r[k][PAL_AW-1:0]];
      end
    end
    if (adv2 && s1_v_r && !s1_pal_r) begin
      out_col_r  <= s1_col_r;
      out_row_r  <= s1_row_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_col   = out_col_r;
  assign out_row   = out_row_r;
  assign out_last  = out_last_r;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      out_colors[k*COLOR_W +: COLOR_W] = color_r[k];
    end
  end

endmodule

// ===== bench/scale3x_pixel_upscaler_top_tb.sv =====
// Self-checking bench for the Scale3x upscaler: table-driven and random frames.
`timescale 1ns / 100ps

module scale3x_pixel_upscaler_top_tb;
  import scx_pkg::*;

  typedef enum {OP_PAL, OP_PIX, OP_CFG} op_t;

  // one table row: palette write, pixel or register write
  typedef struct {
    op_t         op;
    int          addr;    // palette address, pixel code or register index
    logic [31:0] data;
    bit          typed;   // expected block typed in below (1x1 frame)
    logic [31:0] color;
  } stim_row_t;

  typedef struct {
    logic [7:0]  col;
    logic [7:0]  row;
    logic [31:0] px [9];
    logic        last;
  } block_t;

  logic          clk;
  logic          rst_n;
  logic          cfg_valid;
  logic          cfg_ready;
  logic          cfg_index;
  logic [8:0]    cfg_data;
  logic          in_tvalid;
  logic          in_tready;
  logic [47:0]   in_tdata;   // [8:0] pixel_code, [40:9] palette_word, pad
  logic [0:0]    in_tuser;   // [0] kind
  logic          out_tvalid;
  logic          out_tready;
  logic [303:0]  out_tdata;  // [7:0] src_col, [15:8] src_row, E0..E8 from bit 16
  logic          out_tlast;  // last_of_run

  scale3x_pixel_upscaler_top dut (.*);

  // ---------------------------------------------------------------------------
  // predictor state: palette, two line stores, live-row window, position
  // ---------------------------------------------------------------------------
  logic [31:0] pal_mem [PALETTE_SIZE];
  logic [8:0]  older_line [MAX_WIDTH];
  logic [8:0]  recent_line [MAX_WIDTH];
  logic [8:0]  win [2];
  int          colc, rowc;
  logic [8:0]  reg_width, reg_height;
  logic [8:0]  live_code;
  int          live_col, cur_w;

  block_t      block_q [$];   // blocks still owed by the block
  int          err_count;
  int          rx_count;
  bit          pal_known [PALETTE_SIZE];
  int          pal_list [$];  // addresses written so far

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // no idling on either side in this window
  function automatic bit quiet();
    return rx_count >= 150 && rx_count < 400;
  endfunction

  function automatic int clamp_size(logic [8:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // sel: ROW_OLDER / ROW_RECENT line stores, ROW_LIVE the incoming row
  function automatic logic [8:0] pick(logic [1:0] sel, int col);
    if (sel == ROW_LIVE) begin
      if (col == live_col) return live_code;
      if (col + 1 == live_col) return win[1];
      return win[0];
    end
    return (sel == ROW_OLDER) ? older_line[col] : recent_line[col];
  endfunction

  function automatic void predict_block(logic [1:0] top, logic [1:0] mid, logic [1:0] bot,
                                        int col, int row);
    int         l, r;
    logic [8:0] a, b, c, d, e, f, g, h, i;
    logic [8:0] x [9];
    block_t     blk;
    l = (col > 0) ? col - 1 : 0;
    r = (col + 1 < cur_w) ? col + 1 : col;
    a = pick(top, l); b = pick(top, col); c = pick(top, r);
    d = pick(mid, l); e = pick(mid, col); f = pick(mid, r);
    g = pick(bot, l); h = pick(bot, col); i = pick(bot, r);
    for (int k = 0; k < 9; k++) x[k] = e;
    if (b != h && d != f) begin
      if (d == b) x[0] = d;
      if ((d == b && e != c) || (b == f && e != a)) x[1] = b;
      if (b == f) x[2] = f;
      if ((d == b && e != g) || (d == h && e != a)) x[3] = d;
      if ((b == f && e != i) || (h == f && e != c)) x[5] = f;
      if (d == h) x[6] = d;
      if ((d == h && e != i) || (h == f && e != g)) x[7] = h;
      if (h == f) x[8] = f;
    end
    blk.col = col[7:0];
    blk.row = row[7:0];
    for (int k = 0; k < 9; k++) blk.px[k] = pal_mem[x[k]];
    blk.last = 1'b0;
    block_q.push_back(blk);
  endfunction

  function automatic void shift_line(int col, logic [8:0] v);
    older_line[col] = recent_line[col];
    recent_line[col] = v;
  endfunction

  // advance the predictor by one pixel, queue the blocks it releases
  function automatic int predict_pixel(logic [8:0] code);
    int  h, c, r, n;
    bit  row_end, last_row;
    logic [1:0] top;
    cur_w = clamp_size(reg_width, MAX_WIDTH);
    h = clamp_size(reg_height, MAX_HEIGHT);
    c = colc;
    r = rowc;
    live_code = code;
    live_col = c;
    row_end = (c + 1 >= cur_w);
    last_row = (r + 1 >= h);
    n = 0;
    if (r >= 1) begin
      top = (r == 1) ? ROW_RECENT : ROW_OLDER;
      if (c >= 1) begin predict_block(top, ROW_RECENT, ROW_LIVE, c - 1, r - 1); n++; end
      if (row_end) begin predict_block(top, ROW_RECENT, ROW_LIVE, c, r - 1); n++; end
    end
    if (last_row) begin
      top = (r == 0) ? ROW_LIVE : ROW_RECENT;
      if (c >= 1) begin predict_block(top, ROW_LIVE, ROW_LIVE, c - 1, r); n++; end
      if (row_end) begin predict_block(top, ROW_LIVE, ROW_LIVE, c, r); n++; end
    end
    if (c >= 2) shift_line(c - 2, win[0]);
    win[0] = win[1];
    win[1] = code;
    if (row_end) begin
      if (c >= 1) shift_line(c - 1, win[0]);
      shift_line(c, win[1]);
      colc = 0;
      rowc = last_row ? 0 : r + 1;
    end else begin
      colc = c + 1;
    end
    if (n > 0) block_q[block_q.size() - 1].last = 1'b1;
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // request drivers
  // ---------------------------------------------------------------------------
  task automatic send_request(logic kind, logic [8:0] code, logic [31:0] word);
    if (!quiet() && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'b0, word, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_palette(int addr, logic [31:0] word);
    send_request(KIND_PALETTE, addr[8:0], word);
    pal_mem[addr] = word;
    if (!pal_known[addr]) begin
      pal_known[addr] = 1'b1;
      pal_list.push_back(addr);
    end
  endtask

  task automatic send_pixel(logic [8:0] code);
    send_request(KIND_PIXEL, code, $urandom());
    void'(predict_pixel(code));
  endtask

  // registers are written only with nothing in flight
  task automatic write_reg(logic idx, logic [8:0] val);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (block_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_WIDTH) reg_width = val;
    else reg_height = val;
  endtask

  // mostly a small per-frame subset of codes so that neighbors match often
  function automatic logic [8:0] pick_code(int subset [3]);
    if ($urandom_range(99) < 80) return subset[$urandom_range(2)];
    return pal_list[$urandom_range(pal_list.size() - 1)];
  endfunction

  // run pixels (with the odd palette write) until the frame wraps or stop_after pixels are sent
  task automatic run_frame(int stop_after);
    int subset [3];
    int sent;
    for (int k = 0; k < 3; k++) subset[k] = pal_list[$urandom_range(pal_list.size() - 1)];
    sent = 0;
    do begin
      if ($urandom_range(99) < 8)
        write_palette($urandom_range(PALETTE_SIZE - 1), $urandom());
      send_pixel(pick_code(subset));
      sent++;
    end while (!(colc == 0 && rowc == 0) && sent != stop_after);
  endtask

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------
  stim_row_t dir_tab [23] = '{
    '{OP_PAL, 0,   32'h0000_0000, 0, 0},
    '{OP_PAL, 511, 32'hFFFF_FFFF, 0, 0},
    '{OP_PAL, 1,   32'h1111_1111, 0, 0},
    '{OP_PAL, 2,   32'h2222_2222, 0, 0},
    '{OP_PAL, 4,   32'h4444_4444, 0, 0},
    '{OP_PAL, 8,   32'h8888_8888, 0, 0},
    '{OP_PAL, 16,  32'h0F0F_0F0F, 0, 0},
    '{OP_PAL, 32,  32'hF0F0_F0F0, 0, 0},
    '{OP_PAL, 64,  32'h5555_5555, 0, 0},
    '{OP_PAL, 128, 32'hAAAA_AAAA, 0, 0},
    '{OP_PAL, 256, 32'h1234_5678, 0, 0},
    // zero sizes clamp to a single pixel: every neighbor is the pixel itself
    '{OP_CFG, REG_WIDTH,  32'd0, 0, 0},
    '{OP_CFG, REG_HEIGHT, 32'd0, 0, 0},
    '{OP_PIX, 511, 32'd0, 1, 32'hFFFF_FFFF},
    '{OP_PIX, 0,   32'd0, 1, 32'h0000_0000},
    // 3x2 checkerboard exercises the diagonal rules and the edge flushes
    '{OP_CFG, REG_WIDTH,  32'd3, 0, 0},
    '{OP_CFG, REG_HEIGHT, 32'd2, 0, 0},
    '{OP_PIX, 1, 32'd0, 0, 0},
    '{OP_PIX, 2, 32'd0, 0, 0},
    '{OP_PIX, 1, 32'd0, 0, 0},
    '{OP_PIX, 2, 32'd0, 0, 0},
    '{OP_PIX, 1, 32'd0, 0, 0},
    '{OP_PIX, 2, 32'd0, 0, 0}
  };

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    block_t want;
    if (rst_n && out_tvalid && out_tready) begin
      rx_count <= rx_count + 1;
      if (block_q.size() == 0) begin
        report_mismatch("result request with nothing expected");
      end else begin
        want = block_q.pop_front();
        if (out_tdata[7:0] !== want.col)
          report_mismatch($sformatf("src_col %0d, want %0d", out_tdata[7:0], want.col));
        if (out_tdata[15:8] !== want.row)
          report_mismatch($sformatf("src_row %0d, want %0d", out_tdata[15:8], want.row));
        for (int k = 0; k < 9; k++)
          if (out_tdata[16 + 32 * k +: 32] !== want.px[k])
            report_mismatch($sformatf("E%0d at (%0d,%0d) %h, want %h", k, want.col,
                                      want.row, out_tdata[16 + 32 * k +: 32], want.px[k]));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("tlast %b, want %b", out_tlast, want.last));
      end
    end
  end

  // receiver: random back-pressure, one long hold-off so the queue fills
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!held && rx_count >= 100) begin
        held = 1'b1;
        hold_left = 300;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet() || $urandom_range(99) >= 13;
      end
    end
  end

  // run limit
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int pixels;
    int w, h;
    err_count = 0;
    rx_count = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_PIXEL;
    reg_width = 9'd256;
    reg_height = 9'd240;
    colc = 0;
    rowc = 0;
    win[0] = '0;
    win[1] = '0;
    for (int k = 0; k < PALETTE_SIZE; k++) begin
      pal_mem[k] = '0;
      pal_known[k] = 1'b0;
    end
    for (int k = 0; k < MAX_WIDTH; k++) begin
      older_line[k] = '0;
      recent_line[k] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[j]) begin
      case (dir_tab[j].op)
        OP_PAL: write_palette(dir_tab[j].addr, dir_tab[j].data);
        OP_CFG: write_reg(dir_tab[j].addr[0], dir_tab[j].data[8:0]);
        default: begin
          send_pixel(dir_tab[j].addr[8:0]);
          if (dir_tab[j].typed) begin
            // 1x1 frame: one block at the origin, all nine the pixel's color
            block_q[block_q.size() - 1].col = 8'd0;
            block_q[block_q.size() - 1].row = 8'd0;
            for (int k = 0; k < 9; k++) block_q[block_q.size() - 1].px[k] = dir_tab[j].color;
            block_q[block_q.size() - 1].last = 1'b1;
          end
        end
      endcase
    end

    // widest row, width register above the maximum, single row
    write_reg(REG_WIDTH, 9'd300);
    write_reg(REG_HEIGHT, 9'd1);
    run_frame(-1);
    // height register all ones, single column, cut short after 30 rows
    write_reg(REG_WIDTH, 9'd1);
    write_reg(REG_HEIGHT, 9'd511);
    run_frame(30);
    // height shrunk mid-frame: a row past the last row ends the frame
    write_reg(REG_WIDTH, 9'd5);
    write_reg(REG_HEIGHT, 9'd5);
    run_frame(-1);
    // size shrunk mid-frame: the row and then the frame end early
    run_frame(12);
    write_reg(REG_WIDTH, 9'd3);
    write_reg(REG_HEIGHT, 9'd3);
    run_frame(-1);

    pixels = 0;
    while (pixels < 120) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      h = $urandom_range(1, 6);
      write_reg(REG_WIDTH, w[8:0]);
      write_reg(REG_HEIGHT, h[8:0]);
      repeat ($urandom_range(1, 2)) run_frame(-1);
      pixels += 2 * w * h;
    end

    in_tvalid <= 1'b0;
    while (block_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
